>>> rtl/core/glob_wildcard_matcher_defines.svh
// ----------------------------------------------------------------------------
// Glob matcher assertion macros
// Concurrent check helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define GWM_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("gwm: same-cycle check failed");
// next-cycle implication
`define GWM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("gwm: next-cycle check failed");
`else
`define GWM_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define GWM_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> rtl/core/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] STAR_CODE  = 8'h2A;
    localparam logic [7:0] QMARK_CODE = 8'h3F;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_NAME    = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic       no_char;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic too_long;
    } out_item_t;

    // broadcast from the top to every cell
    typedef struct packed {
        logic [7:0] char_code;
        logic       no_char;
        logic       name_active;  // live bits hold a name in progress
        logic       live_load;    // store the advanced live bits
        logic       wr;           // pattern byte write this cycle
    } cell_ctl_t;

    // passed from one cell to the next position
    typedef struct packed {
        logic start;   // position live at the start of a name
        logic adv;     // literal or '?' step into the next position
        logic close;   // star closure into the next position
        logic prefix;  // all stored bytes up to here are '*'
    } handoff_t;

endpackage

`default_nettype wire

>>> rtl/core/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: stored byte, star-prefix bit and live bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF,
    parameter int INDEX       = 0
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire gwm_pkg::cell_ctl_t                 ctl,
    input  wire logic [$clog2(MAX_PATTERN+1)-1:0]   len,
    input  wire logic [$clog2(MAX_PATTERN+1)-1:0]   wr_idx,
    input  wire gwm_pkg::handoff_t                  prev,
    output gwm_pkg::handoff_t                       nxt,
    output logic                                    live_new
);
    import gwm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

    logic [7:0] byte_reg;
    logic       prefix_star_reg;
    logic       live_reg;

    logic used;
    logic base;
    logic hit_star;
    logic hit_one;
    logic adv_self;
    logic stepped;

    assign used     = (len > IDX);
    assign base     = ctl.name_active ? live_reg : prev.start;
    assign hit_star = (byte_reg == STAR_CODE);
    assign hit_one  = (byte_reg == QMARK_CODE) || (byte_reg == ctl.char_code);
    assign adv_self = base & used & hit_star;

    // closure ripples from cell to cell like a carry
    assign stepped  = adv_self | prev.adv | prev.close;
    assign live_new = ctl.no_char ? base : stepped;

    assign nxt.adv    = base & used & ~hit_star & hit_one;
    assign nxt.close  = stepped & used & hit_star;
    assign nxt.start  = prefix_star_reg & used;
    assign nxt.prefix = prefix_star_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr && (wr_idx == IDX))
        begin
            byte_reg        <= ctl.char_code;
            prefix_star_reg <= (ctl.char_code == STAR_CODE) & prev.prefix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (ctl.live_load)
        begin
            live_reg <= live_new;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gwm_out_buf.sv
// ----------------------------------------------------------------------------
// gwm_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire gwm_pkg::out_item_t push_item,
    output logic                    full,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output gwm_pkg::out_item_t      result
);
    import gwm_pkg::*;

    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;
    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      pop;

    assign pop          = main_valid_reg & ~result_stall;
    assign full         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // no push while full
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_item;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Case-sensitive glob matcher ('*' any run, '?' one byte) over a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one byte per item. func 0
//   loads a pattern byte, func 1 streams a name byte; last closes the pattern
//   or name, no_char marks an item without a byte (empty pattern or name).
//   result channel (result_valid / result_stall / result): one item per name,
//   issued for the name item with last set; matched is forced low when the
//   pattern overflowed the MAX_PATTERN-byte store (too_long).
// Throughput: one item per unstalled cycle, pattern or name. Each name byte
//   updates the live bit of every pattern position at once; star closure
//   ripples through the cell row like a carry chain, setting the cycle time.
// Latency: if no result is held, result_valid is set the cycle after the name.
// Stall: results sit in a two-entry buffer; item_stall rises only while both
//   entries are held, so items keep flowing under a short result stall.
// Reset: no pattern stored (length zero), no name in progress, buffer empty.
//   Pattern bytes are not cleared; only stored positions are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glob_wildcard_matcher_defines.svh"

module glob_wildcard_matcher #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire gwm_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output gwm_pkg::out_item_t      result
);
    import gwm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    // control state
    logic [LEN_W-1:0] len_reg, len_next;
    logic             too_long_reg, too_long_next;
    logic             pat_active_reg, pat_active_next;
    logic             name_active_reg, name_active_next;
    logic             term_live_reg;

    logic             accept;
    logic             pat_acc;
    logic             name_acc;
    logic [LEN_W-1:0] eff_len;
    logic             has_room;
    logic             push;
    logic             buf_full;
    out_item_t        push_item;
    cell_ctl_t        ctl;

    handoff_t             chain [MAX_PATTERN+1];
    logic [MAX_PATTERN:0] live_vec;
    logic                 term_base;

    assign accept     = item_valid & ~item_stall;
    assign pat_acc    = accept & (item.func == FUNC_PATTERN);
    assign name_acc   = accept & (item.func == FUNC_NAME);
    assign item_stall = buf_full;

    // a pattern item with no pattern in progress starts a new one
    assign eff_len  = pat_active_reg ? len_reg : '0;
    assign has_room = (eff_len < LEN_MAX);

    assign ctl.char_code   = item.char_code;
    assign ctl.no_char     = item.no_char;
    assign ctl.name_active = name_active_reg;
    assign ctl.live_load   = name_acc & ~item.last;
    assign ctl.wr          = pat_acc & ~item.no_char & has_room;

    // position zero is always live when a name starts
    assign chain[0].start  = 1'b1;
    assign chain[0].adv    = 1'b0;
    assign chain[0].close  = 1'b0;
    assign chain[0].prefix = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        gwm_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .INDEX       (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .len      (len_reg),
            .wr_idx   (eff_len),
            .prev     (chain[i]),
            .nxt      (chain[i+1]),
            .live_new (live_vec[i])
        );
    end

    // end-of-store position: live means a full-length pattern is consumed
    assign term_base = name_active_reg ? term_live_reg : chain[MAX_PATTERN].start;
    assign live_vec[MAX_PATTERN] = item.no_char ? term_base
                                 : (chain[MAX_PATTERN].adv | chain[MAX_PATTERN].close);

    assign push               = name_acc & item.last;
    assign push_item.matched  = live_vec[len_reg] & ~too_long_reg;
    assign push_item.too_long = too_long_reg;

    always_comb
    begin
        len_next         = len_reg;
        too_long_next    = too_long_reg;
        pat_active_next  = pat_active_reg;
        name_active_next = name_active_reg;
        if (pat_acc)
        begin
            len_next         = eff_len + LEN_W'(ctl.wr);
            too_long_next    = (pat_active_reg & too_long_reg)
                             | (~item.no_char & ~has_room);
            pat_active_next  = ~item.last;
            name_active_next = 1'b0;   // drops any name in progress
        end
        else if (name_acc)
        begin
            name_active_next = ~item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= '0;
            too_long_reg    <= 1'b0;
            pat_active_reg  <= 1'b0;
            name_active_reg <= 1'b0;
            term_live_reg   <= 1'b0;
        end
        else
        begin
            len_reg         <= len_next;
            too_long_reg    <= too_long_next;
            pat_active_reg  <= pat_active_next;
            name_active_reg <= name_active_next;
            if (ctl.live_load)
            begin
                term_live_reg <= live_vec[MAX_PATTERN];
            end
        end
    end

    gwm_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // input backs up only while the result buffer holds a waiting result
    `GWM_ASSERT_IMPLY(a_stall_needs_result, clk, rst_n, item_stall, result_valid)
    // overflow can only be flagged with the store full
    `GWM_ASSERT_IMPLY(a_overflow_full, clk, rst_n, too_long_reg, len_reg == LEN_MAX)
    // a closing name item always yields a visible result
    `GWM_ASSERT_NEXT(a_name_result, clk, rst_n, push, result_valid)

endmodule

`default_nettype wire
